// ===== rtl/clock_calendar_with_set_menu_core_defines.svh =====
// ----------------------------------------------------------------------------
// clock calendar assertion macros
// shared assertion helpers for the clock calendar core, empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef CLOCK_CALENDAR_WITH_SET_MENU_CORE_DEFINES_SVH
`define CLOCK_CALENDAR_WITH_SET_MENU_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define CCSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CCSM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/ccsm_pkg.sv =====
// ----------------------------------------------------------------------------
// ccsm_pkg
// types, constants and decode helpers for the clock calendar core
// ----------------------------------------------------------------------------
package ccsm_pkg;

    typedef enum logic [2:0] {
        MODE_TIME      = 3'd0,
        MODE_DATE      = 3'd1,
        MODE_AL0_START = 3'd2,
        MODE_AL0_END   = 3'd3,
        MODE_AL1_START = 3'd4,
        MODE_AL1_END   = 3'd5
    } t_mode;

    typedef struct packed {
        logic  valid;
        t_mode nxt;
    } t_move;

    typedef struct packed {
        logic [6:0] low_ones;
        logic [6:0] low_tens;
        logic [6:0] mid_ones;
        logic [6:0] mid_tens;
        logic [6:0] high_ones;
        logic [6:0] high_tens;
    } t_segs;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    // button bit positions
    localparam int BTN_MIN_UP = 3;
    localparam int BTN_HR_UP  = 4;

    localparam logic [5:0] MIN_LAST   = 6'd59;
    localparam logic [4:0] HR_LAST    = 5'd23;
    localparam logic [4:0] DAY_LONG   = 5'd31;
    localparam logic [3:0] MONTH_HALF = 4'd7;
    localparam logic [3:0] MONTH_END  = 4'd13;
    localparam logic [6:0] YEAR_LAST  = 7'd99;
    localparam logic [6:0] YEAR_FIRST = 7'd97;

    localparam logic [5:0] AL_MIN_RST [4] = '{6'd10, 6'd12, 6'd14, 6'd16};
    localparam logic [4:0] AL_HR_RST  [4] = '{5'd11, 5'd13, 5'd15, 5'd17};

    // menu transition for key k from mode m
    function automatic t_move menu_next(input t_mode m, input logic [1:0] k);
        t_move r;
        r = '{valid: 1'b0, nxt: MODE_TIME};
        case (m)
            MODE_TIME, MODE_DATE: begin
                case (k)
                    2'd0: r = '{valid: 1'b1, nxt: (m == MODE_TIME) ? MODE_DATE : MODE_TIME};
                    2'd1: r = '{valid: 1'b1, nxt: MODE_AL0_START};
                    2'd2: r = '{valid: 1'b1, nxt: MODE_AL1_START};
                    default: r = '{valid: 1'b0, nxt: MODE_TIME};
                endcase
            end
            MODE_AL0_START: if (k == 2'd1) r = '{valid: 1'b1, nxt: MODE_AL0_END};
            MODE_AL0_END:   if (k == 2'd1) r = '{valid: 1'b1, nxt: MODE_TIME};
            MODE_AL1_START: if (k == 2'd2) r = '{valid: 1'b1, nxt: MODE_AL1_END};
            MODE_AL1_END:   if (k == 2'd2) r = '{valid: 1'b1, nxt: MODE_TIME};
            default: r = '{valid: 1'b0, nxt: MODE_TIME};
        endcase
        return r;
    endfunction

    // gfedcba pattern, dark above nine
    function automatic logic [6:0] seg_of(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0: s = 7'h3F;
            4'd1: s = 7'h06;
            4'd2: s = 7'h5B;
            4'd3: s = 7'h4F;
            4'd4: s = 7'h66;
            4'd5: s = 7'h6D;
            4'd6: s = 7'h7D;
            4'd7: s = 7'h07;
            4'd8: s = 7'h7F;
            4'd9: s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/clock_calendar_with_set_menu_core.sv =====
// ----------------------------------------------------------------------------
// clock_calendar_with_set_menu_core
// time of day, solar calendar and a six-screen setting menu with display decode
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready): one request per event, i_kind 0
//   is a one-second tick, i_kind 1 a button sample carrying i_buttons
//   output channel (o_out_valid / i_out_ready): one result per request, the
//   menu screen, the alarm flag and six seven-segment digits
//   the clock state is updated at the edge that accepts a request; the state
//   registers then feed the result register, loaded once the output side is free
//   throughput: one request per cycle while results are taken, set by the
//   single state register stage followed by the result register
//   a stalled receiver holds the result register; one more request may be
//   taken and parked in the state registers, then o_in_ready drops until the
//   result is taken
//   reset (synchronous, active low): 00:00:00, day 1 month 1 year 97, the four
//   alarm set points at their defaults, time screen, both channels empty
// ----------------------------------------------------------------------------
`include "clock_calendar_with_set_menu_core_defines.svh"

module clock_calendar_with_set_menu_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_kind,
    input  logic [4:0] i_buttons,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_menu_mode,
    output logic       o_alarm_on,
    output logic [6:0] o_seg_low_ones,
    output logic [6:0] o_seg_low_tens,
    output logic [6:0] o_seg_mid_ones,
    output logic [6:0] o_seg_mid_tens,
    output logic [6:0] o_seg_high_ones,
    output logic [6:0] o_seg_high_tens
);
    import ccsm_pkg::*;

    // clock and calendar state
    logic [5:0] r_sec,   n_sec;
    logic [5:0] r_min,   n_min;
    logic [4:0] r_hour,  n_hour;
    logic [4:0] r_day,   n_day;
    logic [3:0] r_month, n_month;
    logic [6:0] r_year,  n_year;
    logic [5:0] r_al_min [4];
    logic [5:0] n_al_min [4];
    logic [4:0] r_al_hr  [4];
    logic [4:0] n_al_hr  [4];
    t_mode      r_mode,  n_mode;

    // handshake control
    logic r_pend;      // state holds a request not yet rendered
    logic r_out_valid;
    logic w_in_acc;
    logic w_load;      // result register takes the pending request

    // result register
    t_mode r_res_mode;
    logic  r_res_alarm;
    t_segs r_res_segs;

    // display path
    logic [6:0] w_hi, w_mid, w_lo;
    t_segs      w_segs;
    logic       w_alarm;
    logic [1:0] w_edit_idx;

    function automatic logic [5:0] bump_min(input logic [5:0] m);
        return (m >= MIN_LAST) ? 6'd0 : m + 6'd1;
    endfunction

    function automatic logic [4:0] bump_hr(input logic [4:0] h);
        return (h >= HR_LAST) ? 5'd0 : h + 5'd1;
    endfunction

    assign w_load     = r_pend && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_pend || w_load;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // state update for one request
    // ------------------------------------------------------------------
    always_comb begin
        t_move      mv;
        logic       moved;
        logic [1:0] eidx;
        n_sec    = r_sec;
        n_min    = r_min;
        n_hour   = r_hour;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_al_min = r_al_min;
        n_al_hr  = r_al_hr;
        n_mode   = r_mode;
        moved    = 1'b0;
        mv       = '{valid: 1'b0, nxt: MODE_TIME};
        eidx     = 2'd0;
        if (w_in_acc) begin
            if (i_kind == KIND_TICK) begin
                // carry chain: seconds, minutes, hours, day, month, year
                n_sec = r_sec + 6'd1;
                if (n_sec >= 6'd60) begin
                    n_sec = 6'd0;
                    n_min = r_min + 6'd1;
                end
                if (n_min >= 6'd60) begin
                    n_min  = 6'd0;
                    n_hour = r_hour + 5'd1;
                end
                if (n_hour > HR_LAST) begin
                    n_hour = 5'd0;
                    n_day  = r_day + 5'd1;
                end
                // second half of the year has 30-day months
                if (n_day == DAY_LONG && n_month >= MONTH_HALF) begin
                    n_day   = 5'd1;
                    n_month = n_month + 4'd1;
                end
                // 31-day month wraps through zero
                if (n_day == 5'd0) begin
                    n_day   = 5'd1;
                    n_month = n_month + 4'd1;
                end
                if (n_month >= MONTH_END || n_month == 4'd0) begin
                    n_month = 4'd1;
                    n_year  = r_year + 7'd1;
                end
                if (n_year > YEAR_LAST) begin
                    n_year = YEAR_FIRST;
                end
            end else begin
                // first pressed menu key with a transition wins
                for (int k = 0; k < 3; k++) begin
                    mv = menu_next(r_mode, 2'(k));
                    if (!moved && i_buttons[k] && mv.valid) begin
                        n_mode = mv.nxt;
                        moved  = 1'b1;
                    end
                end
                case (n_mode)
                    MODE_TIME: begin
                        if (i_buttons[BTN_MIN_UP]) n_min  = bump_min(r_min);
                        if (i_buttons[BTN_HR_UP])  n_hour = bump_hr(r_hour);
                    end
                    MODE_AL0_START, MODE_AL0_END, MODE_AL1_START, MODE_AL1_END: begin
                        eidx = 2'(n_mode - MODE_AL0_START);
                        if (i_buttons[BTN_MIN_UP]) n_al_min[eidx] = bump_min(r_al_min[eidx]);
                        if (i_buttons[BTN_HR_UP])  n_al_hr[eidx]  = bump_hr(r_al_hr[eidx]);
                    end
                    default: begin
                        // date screen edits nothing
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec    <= 6'd0;
            r_min    <= 6'd0;
            r_hour   <= 5'd0;
            r_day    <= 5'd1;
            r_month  <= 4'd1;
            r_year   <= YEAR_FIRST;
            r_al_min <= AL_MIN_RST;
            r_al_hr  <= AL_HR_RST;
            r_mode   <= MODE_TIME;
        end else begin
            r_sec    <= n_sec;
            r_min    <= n_min;
            r_hour   <= n_hour;
            r_day    <= n_day;
            r_month  <= n_month;
            r_year   <= n_year;
            r_al_min <= n_al_min;
            r_al_hr  <= n_al_hr;
            r_mode   <= n_mode;
        end
    end

    // ------------------------------------------------------------------
    // display selection from the updated state
    // ------------------------------------------------------------------
    assign w_edit_idx = 2'(r_mode - MODE_AL0_START);

    always_comb begin
        case (r_mode)
            MODE_DATE: begin
                w_hi  = r_year;
                w_mid = {3'd0, r_month};
                w_lo  = {2'd0, r_day};
            end
            MODE_AL0_START, MODE_AL0_END, MODE_AL1_START, MODE_AL1_END: begin
                w_hi  = {2'd0, r_al_hr[w_edit_idx]};
                w_mid = {1'b0, r_al_min[w_edit_idx]};
                w_lo  = 7'd0;
            end
            default: begin
                w_hi  = {2'd0, r_hour};
                w_mid = {1'b0, r_min};
                w_lo  = {1'b0, r_sec};
            end
        endcase
    end

    assign w_alarm = (r_hour == r_al_hr[0]) && (r_min == r_al_min[0]);

    ccsm_disp u_disp (
        .i_hi   (w_hi),
        .i_mid  (w_mid),
        .i_lo   (w_lo),
        .o_segs (w_segs)
    );

    // ------------------------------------------------------------------
    // handshake and result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res_mode  <= r_mode;
            r_res_alarm <= w_alarm;
            r_res_segs  <= w_segs;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_menu_mode     = r_res_mode;
    assign o_alarm_on      = r_res_alarm;
    assign o_seg_low_ones  = r_res_segs.low_ones;
    assign o_seg_low_tens  = r_res_segs.low_tens;
    assign o_seg_mid_ones  = r_res_segs.mid_ones;
    assign o_seg_mid_tens  = r_res_segs.mid_tens;
    assign o_seg_high_ones = r_res_segs.high_ones;
    assign o_seg_high_tens = r_res_segs.high_tens;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an accepted request is always parked for rendering
    `CCSM_ASSERT_NEXT(a_acc_pend, i_clk, i_rst_n, w_in_acc, r_pend)
    // a rendered request always shows up at the output
    `CCSM_ASSERT_NEXT(a_load_out, i_clk, i_rst_n, w_load, o_out_valid)
    // counters stay inside their calendar ranges
    `CCSM_ASSERT_NOW(a_ranges, i_clk, i_rst_n, 1'b1,
        (r_sec < 6'd60) && (r_min < 6'd60) && (r_hour <= HR_LAST) && (r_day != 5'd0) &&
        (r_month != 4'd0) && (r_month < MONTH_END) && (r_year >= YEAR_FIRST) &&
        (r_year <= YEAR_LAST))

endmodule

// ===== rtl/ccsm_disp.sv =====
// ----------------------------------------------------------------------------
// ccsm_disp
// splits three shown values into decimal digits and seven-segment codes
// ----------------------------------------------------------------------------
module ccsm_disp (
    input  logic [6:0]     i_hi,
    input  logic [6:0]     i_mid,
    input  logic [6:0]     i_lo,
    output ccsm_pkg::t_segs o_segs
);
    import ccsm_pkg::*;

    // tens by reciprocal multiply (x*205 >> 11), exact for seven-bit values
    function automatic logic [7:0] split(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = {8'd0, v} * 15'd205;
        tens = prod[14:11];
        ones = v - 7'({3'd0, tens} * 7'd10);
        return {tens, ones[3:0]};
    endfunction

    logic [7:0] w_hi;
    logic [7:0] w_mid;
    logic [7:0] w_lo;

    assign w_hi  = split(i_hi);
    assign w_mid = split(i_mid);
    assign w_lo  = split(i_lo);

    assign o_segs.low_ones  = seg_of(w_lo[3:0]);
    assign o_segs.low_tens  = seg_of(w_lo[7:4]);
    assign o_segs.mid_ones  = seg_of(w_mid[3:0]);
    assign o_segs.mid_tens  = seg_of(w_mid[7:4]);
    assign o_segs.high_ones = seg_of(w_hi[3:0]);
    assign o_segs.high_tens = seg_of(w_hi[7:4]);

endmodule
